// ----- src/srd_pkg.sv -----
// ----------------------------------------------------------------------------
// srd_pkg: shared types and constants for the radial dead zone block
// Register codes, axis codes, fixed-point constants and the lane status struct.
// ----------------------------------------------------------------------------
package srd_pkg;

   localparam int PAD_SLOTS_DEFAULT = 8;

   localparam logic [14:0] Q_ONE      = 15'd32767;
   localparam logic [14:0] DZ_MAX     = 15'd32766;
   localparam logic [14:0] DZ_RESET   = 15'd4915;
   localparam logic [16:0] MOVE_STEP  = 17'd66;

   // register index (paddr[2])
   localparam logic REG_DEAD_ZONE = 1'b0;
   localparam logic REG_SIDEWAYS  = 1'b1;

   // pad styles
   localparam logic [1:0] STYLE_FULL  = 2'd0;
   localparam logic [1:0] STYLE_LEFT  = 2'd1;
   localparam logic [1:0] STYLE_RIGHT = 2'd2;

   // axis codes
   localparam logic [1:0] AXIS_LX = 2'd0;
   localparam logic [1:0] AXIS_LY = 2'd1;
   localparam logic [1:0] AXIS_RX = 2'd2;
   localparam logic [1:0] AXIS_RY = 2'd3;

   typedef struct packed {
      logic               done;
      logic signed [15:0] value;
   } lane_out_type;

endpackage

// ----- src/srd_req_if.sv -----
// ----------------------------------------------------------------------------
// srd_req_if: input item channel
// One pad frame: slot, detach flag, style and four raw stick positions.
// ----------------------------------------------------------------------------
interface srd_req_if;
   logic               valid;
   logic               ready;
   logic [2:0]         pad_slot;
   logic               detach;
   logic [1:0]         pad_style;
   logic signed [15:0] stick0_x;
   logic signed [15:0] stick0_y;
   logic signed [15:0] stick1_x;
   logic signed [15:0] stick1_y;

   modport source (output valid, pad_slot, detach, pad_style, stick0_x, stick0_y,
                   stick1_x, stick1_y, input ready);
   modport sink   (input valid, pad_slot, detach, pad_style, stick0_x, stick0_y,
                   stick1_x, stick1_y, output ready);
endinterface

// ----- src/srd_rsp_if.sv -----
// ----------------------------------------------------------------------------
// srd_rsp_if: result item channel
// One axis event: slot, axis code, conditioned value and last-in-frame flag.
// ----------------------------------------------------------------------------
interface srd_rsp_if;
   logic               valid;
   logic               ready;
   logic [2:0]         out_slot;
   logic [1:0]         axis_code;
   logic signed [15:0] axis_value;
   logic               last_event;

   modport source (output valid, out_slot, axis_code, axis_value, last_event,
                   input ready);
   modport sink   (input valid, out_slot, axis_code, axis_value, last_event,
                   output ready);
endinterface

// ----- src/srd_ram.sv -----
// ----------------------------------------------------------------------------
// srd_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module srd_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ----- src/srd_lane.sv -----
// ----------------------------------------------------------------------------
// srd_lane: one axis of the radial dead zone
// Squares, bit-serial square root, rescale products and a restoring divider.
// ----------------------------------------------------------------------------
module srd_lane (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic signed [16:0]   a,
   input  logic signed [16:0]   b,
   input  logic [14:0]          dz,
   output srd_pkg::lane_out_type status
);

   typedef enum logic [7:0] {
      L_IDLE = 8'b0000_0001,
      L_SQ   = 8'b0000_0010,
      L_SUM  = 8'b0000_0100,
      L_ROOT = 8'b0000_1000,
      L_MUL  = 8'b0001_0000,
      L_NUM  = 8'b0010_0000,
      L_SAT  = 8'b0100_0000,
      L_DIV  = 8'b1000_0000
   } lane_state_type;

   lane_state_type     state_ff, state_in;
   logic               done_ff, done_in;
   logic [16:0]        ua_ff, ua_in;
   logic [16:0]        ub_ff, ub_in;
   logic               neg_ff, neg_in;
   logic [14:0]        dz_ff, dz_in;
   logic [30:0]        sqa_ff, sqa_in;
   logic [30:0]        sqb_ff, sqb_in;
   logic [29:0]        dz2_ff, dz2_in;
   logic [31:0]        rem_ff, rem_in;
   logic [31:0]        root_ff, root_in;
   logic [3:0]         it_ff, it_in;
   logic [15:0]        m_ff, m_in;
   logic [32:0]        p1_ff, p1_in;
   logic [30:0]        den_ff, den_in;
   logic [47:0]        n_ff, n_in;
   logic [14:0]        q_ff, q_in;
   logic signed [15:0] value_ff, value_in;

   logic [33:0] prod_a, prod_b;
   logic [29:0] prod_dz;
   logic [31:0] sum_s;
   logic [31:0] root_bit;
   logic [32:0] root_trial;
   logic [31:0] root_next;
   logic [15:0] m_diff;
   logic [32:0] prod_p1;
   logic [30:0] prod_den;
   logic [47:0] den_shift;

   assign prod_a     = 34'(ua_ff) * 34'(ua_ff);
   assign prod_b     = 34'(ub_ff) * 34'(ub_ff);
   assign prod_dz    = 30'(dz_ff) * 30'(dz_ff);
   assign sum_s      = {1'b0, sqa_ff} + {1'b0, sqb_ff};
   assign root_bit   = 32'd1 << {it_ff, 1'b0};
   assign root_trial = {1'b0, root_ff} + {1'b0, root_bit};
   assign root_next  = ({1'b0, rem_ff} >= root_trial) ? ((root_ff >> 1) + root_bit)
                                                       : (root_ff >> 1);
   assign m_diff     = m_ff - {1'b0, dz_ff};
   assign prod_p1    = 33'(ua_ff) * 33'(m_diff);
   assign prod_den   = 31'(m_ff) * 31'(srd_pkg::Q_ONE - dz_ff);
   assign den_shift  = {17'd0, den_ff} << it_ff;

   always_comb begin
      state_in = state_ff;
      done_in  = done_ff;
      ua_in    = ua_ff;
      ub_in    = ub_ff;
      neg_in   = neg_ff;
      dz_in    = dz_ff;
      sqa_in   = sqa_ff;
      sqb_in   = sqb_ff;
      dz2_in   = dz2_ff;
      rem_in   = rem_ff;
      root_in  = root_ff;
      it_in    = it_ff;
      m_in     = m_ff;
      p1_in    = p1_ff;
      den_in   = den_ff;
      n_in     = n_ff;
      q_in     = q_ff;
      value_in = value_ff;

      case (state_ff)
         L_IDLE: begin
            if (start) begin
               ua_in    = a[16] ? 17'(-a) : 17'(a);
               ub_in    = b[16] ? 17'(-b) : 17'(b);
               neg_in   = a[16];
               dz_in    = dz;
               done_in  = 1'b0;
               state_in = L_SQ;
            end
         end
         L_SQ: begin
            sqa_in   = prod_a[30:0];
            sqb_in   = prod_b[30:0];
            dz2_in   = prod_dz;
            state_in = L_SUM;
         end
         L_SUM: begin
            if (sum_s < {2'b0, dz2_ff}) begin
               value_in = '0;
               done_in  = 1'b1;
               state_in = L_IDLE;
            end else begin
               rem_in   = sum_s;
               root_in  = '0;
               it_in    = 4'd15;
               state_in = L_ROOT;
            end
         end
         L_ROOT: begin
            // one result bit per cycle
            if ({1'b0, rem_ff} >= root_trial) begin
               rem_in = rem_ff - root_trial[31:0];
            end
            root_in = root_next;
            it_in   = it_ff - 4'd1;
            if (it_ff == 4'd0) begin
               m_in = root_next[15:0];
               if (root_next == '0) begin
                  value_in = '0;
                  done_in  = 1'b1;
                  state_in = L_IDLE;
               end else begin
                  state_in = L_MUL;
               end
            end
         end
         L_MUL: begin
            p1_in    = prod_p1;
            den_in   = prod_den;
            state_in = L_NUM;
         end
         L_NUM: begin
            // p1 * 32767 plus half the divisor for rounding
            n_in     = {p1_ff, 15'd0} - {15'd0, p1_ff} + {18'd0, den_ff[30:1]};
            state_in = L_SAT;
         end
         L_SAT: begin
            if (n_ff >= {2'b0, den_ff, 15'd0}) begin
               value_in = neg_ff ? -16'sd32767 : 16'sd32767;
               done_in  = 1'b1;
               state_in = L_IDLE;
            end else begin
               q_in     = '0;
               it_in    = 4'd14;
               state_in = L_DIV;
            end
         end
         L_DIV: begin
            if (n_ff >= den_shift) begin
               n_in         = n_ff - den_shift;
               q_in[it_ff]  = 1'b1;
            end
            it_in = it_ff - 4'd1;
            if (it_ff == 4'd0) begin
               value_in = neg_ff ? -$signed({1'b0, q_in}) : $signed({1'b0, q_in});
               done_in  = 1'b1;
               state_in = L_IDLE;
            end
         end
         default: begin
            state_in = L_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= L_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      ua_ff    <= ua_in;
      ub_ff    <= ub_in;
      neg_ff   <= neg_in;
      dz_ff    <= dz_in;
      sqa_ff   <= sqa_in;
      sqb_ff   <= sqb_in;
      dz2_ff   <= dz2_in;
      rem_ff   <= rem_in;
      root_ff  <= root_in;
      it_ff    <= it_in;
      m_ff     <= m_in;
      p1_ff    <= p1_in;
      den_ff   <= den_in;
      n_ff     <= n_in;
      q_ff     <= q_in;
      value_ff <= value_in;
   end

   assign status.done  = done_ff;
   assign status.value = value_ff;

endmodule

// ----- src/stick_radial_deadzone_core.sv -----
// ----------------------------------------------------------------------------
// stick_radial_deadzone_core: two-stick radial dead zone with change filter
// Four axis lanes condition one frame in parallel; a merge stage filters
// against the stored per-slot values and emits axis events.
// ----------------------------------------------------------------------------
// Usage:
//   req_ch carries one pad frame per item; rsp_ch carries zero to four axis
//   events per frame in order left x, left y, right x, right y, the final one
//   flagged by last_event. csr_* is an APB write/read port for dead_zone
//   (address 0) and sideways_mode (address 4); pready is tied high.
//   Items are taken one at a time: req_ch.ready is high only while the block
//   is idle. A frame is accepted, waits in T_RUN until all four lanes are
//   done (16 square-root steps plus 15 divider steps dominate the lane
//   work), then reads the stored values from the RAM in T_READ and emits
//   in T_EMIT, which pauses while the receiver stalls the output register.
//   A detach item or an out-of-range slot is absorbed in its accept cycle.
//   Reset returns the configuration and control state to defaults and marks
//   every stored axis value as zero through per-entry valid bits, so no
//   clearing pass is run. When rsp_ch.ready is low the pending event waits
//   in the output register and the emit sequence pauses; nothing is dropped.
// ----------------------------------------------------------------------------
module stick_radial_deadzone_core #(
   parameter int PAD_SLOTS = srd_pkg::PAD_SLOTS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   srd_req_if.sink     req_ch,
   srd_rsp_if.source   rsp_ch,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int DEPTH   = PAD_SLOTS * 4;
   localparam int ENTRY_W = $clog2(DEPTH);

   typedef enum logic [3:0] {
      T_IDLE = 4'b0001,
      T_RUN  = 4'b0010,
      T_READ = 4'b0100,
      T_EMIT = 4'b1000
   } top_state_type;

   function automatic logic [ENTRY_W-1:0] entry_of(input logic [2:0] slot,
                                                   input logic [1:0] k);
      logic [5:0] full;
      full = {1'b0, slot, k};
      return full[ENTRY_W-1:0];
   endfunction

   // configuration
   logic [14:0] dead_zone_ff;
   logic        sideways_ff;
   logic        csr_write;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         dead_zone_ff <= srd_pkg::DZ_RESET;
         sideways_ff  <= 1'b0;
      end else if (csr_write) begin
         if (csr_paddr[2] == srd_pkg::REG_DEAD_ZONE) begin
            dead_zone_ff <= csr_pwdata[14:0];
         end else begin
            sideways_ff <= csr_pwdata[0];
         end
      end
   end

   assign csr_prdata = (csr_paddr[2] == srd_pkg::REG_DEAD_ZONE) ? {17'd0, dead_zone_ff}
                                                               : {31'd0, sideways_ff};

   // control
   top_state_type state_ff, state_in;
   logic [2:0]    slot_ff;
   logic [2:0]    rk_ff, rk_in;
   logic [1:0]    ek_ff, ek_in;
   logic [3:0]    emit_ff, emit_in;
   logic [DEPTH-1:0] valid_ff, valid_in;

   logic rsp_valid_ff, rsp_valid_in;
   logic [2:0] rsp_slot_ff, rsp_slot_in;
   logic [1:0] rsp_code_ff, rsp_code_in;
   logic signed [15:0] rsp_value_ff, rsp_value_in;
   logic rsp_last_ff, rsp_last_in;

   logic req_take;
   logic slot_ok;
   logic [14:0] dz_eff;
   logic lane_start;
   logic signed [16:0] lx, ly, rx, ry, tmp;
   logic signed [16:0] lane_a [4];
   logic signed [16:0] lane_b [4];
   srd_pkg::lane_out_type lane_st [4];
   logic signed [15:0] val [4];
   logic all_done;

   logic              ram_we;
   logic [ENTRY_W-1:0] ram_waddr, ram_raddr;
   logic [15:0]       ram_rdata;
   logic [1:0]        k_prev;
   logic signed [15:0] prev_val;
   logic signed [16:0] diff;
   logic [16:0]       diff_mag;
   logic              out_free;
   logic [3:0]        mask_above;

   assign req_ch.ready = (state_ff == T_IDLE);
   assign req_take     = req_ch.valid && req_ch.ready;
   assign slot_ok      = {2'b0, req_ch.pad_slot} < 5'(PAD_SLOTS);
   assign dz_eff       = (dead_zone_ff > srd_pkg::DZ_MAX) ? srd_pkg::DZ_MAX : dead_zone_ff;
   assign lane_start   = req_take && slot_ok && !req_ch.detach;

   // stick routing and quarter turn
   always_comb begin
      if (req_ch.pad_style == srd_pkg::STYLE_RIGHT) begin
         lx = 17'(req_ch.stick1_x);
         ly = 17'(req_ch.stick1_y);
         rx = 17'(req_ch.stick0_x);
         ry = 17'(req_ch.stick0_y);
      end else begin
         lx = 17'(req_ch.stick0_x);
         ly = 17'(req_ch.stick0_y);
         rx = 17'(req_ch.stick1_x);
         ry = 17'(req_ch.stick1_y);
      end
      tmp = lx;
      if (sideways_ff && req_ch.pad_style == srd_pkg::STYLE_LEFT) begin
         lx = -ly;
         ly = tmp;
      end else if (sideways_ff && req_ch.pad_style == srd_pkg::STYLE_RIGHT) begin
         lx = ly;
         ly = -tmp;
      end
      lane_a[0] = lx; lane_b[0] = ly;
      lane_a[1] = ly; lane_b[1] = lx;
      lane_a[2] = rx; lane_b[2] = ry;
      lane_a[3] = ry; lane_b[3] = rx;
   end

   for (genvar g = 0; g < 4; g++) begin : g_lane
      srd_lane u_lane (
         .clock  (clock),
         .reset  (reset),
         .start  (lane_start),
         .a      (lane_a[g]),
         .b      (lane_b[g]),
         .dz     (dz_eff),
         .status (lane_st[g])
      );
   end

   // y axes are negated
   assign val[0] = lane_st[0].value;
   assign val[1] = -lane_st[1].value;
   assign val[2] = lane_st[2].value;
   assign val[3] = -lane_st[3].value;
   assign all_done = lane_st[0].done && lane_st[1].done && lane_st[2].done
                     && lane_st[3].done;

   srd_ram #(
      .WIDTH (16),
      .DEPTH (DEPTH)
   ) u_prev_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (val[ek_ff]),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // read data in T_READ belongs to the entry addressed in the previous cycle
   assign k_prev     = rk_ff[1:0] - 2'd1;
   assign ram_raddr  = entry_of(slot_ff, rk_ff[1:0]);
   assign ram_waddr  = entry_of(slot_ff, ek_ff);
   assign prev_val   = valid_ff[entry_of(slot_ff, k_prev)] ? $signed(ram_rdata) : 16'sd0;
   assign diff       = 17'(val[k_prev]) - 17'(prev_val);
   assign diff_mag   = diff[16] ? 17'(-diff) : 17'(diff);
   assign out_free   = !rsp_valid_ff || rsp_ch.ready;
   assign mask_above = 4'(4'b1110 << ek_ff);
   assign ram_we     = (state_ff == T_EMIT) && emit_ff[ek_ff] && out_free;

   always_comb begin
      state_in     = state_ff;
      rk_in        = rk_ff;
      ek_in        = ek_ff;
      emit_in      = emit_ff;
      valid_in     = valid_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_slot_in  = rsp_slot_ff;
      rsp_code_in  = rsp_code_ff;
      rsp_value_in = rsp_value_ff;
      rsp_last_in  = rsp_last_ff;

      case (state_ff)
         T_IDLE: begin
            if (req_take && slot_ok) begin
               if (req_ch.detach) begin
                  for (int k = 0; k < 4; k++) begin
                     valid_in[entry_of(req_ch.pad_slot, 2'(k))] = 1'b0;
                  end
               end else begin
                  state_in = T_RUN;
               end
            end
         end
         T_RUN: begin
            if (all_done) begin
               rk_in    = '0;
               state_in = T_READ;
            end
         end
         T_READ: begin
            rk_in = rk_ff + 3'd1;
            if (rk_ff != 3'd0) begin
               emit_in[k_prev] = (diff_mag >= srd_pkg::MOVE_STEP);
            end
            if (rk_ff == 3'd4) begin
               ek_in    = '0;
               state_in = T_EMIT;
            end
         end
         T_EMIT: begin
            if (!emit_ff[ek_ff] || out_free) begin
               if (emit_ff[ek_ff]) begin
                  valid_in[ram_waddr] = 1'b1;
                  rsp_valid_in = 1'b1;
                  rsp_slot_in  = slot_ff;
                  rsp_code_in  = ek_ff;
                  rsp_value_in = val[ek_ff];
                  rsp_last_in  = (emit_ff & mask_above) == 4'd0;
               end
               ek_in = ek_ff + 2'd1;
               if (ek_ff == srd_pkg::AXIS_RY) begin
                  state_in = T_IDLE;
               end
            end
         end
         default: begin
            state_in = T_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= T_IDLE;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (lane_start) begin
         slot_ff <= req_ch.pad_slot;
      end
      rk_ff        <= rk_in;
      ek_ff        <= ek_in;
      emit_ff      <= emit_in;
      rsp_slot_ff  <= rsp_slot_in;
      rsp_code_ff  <= rsp_code_in;
      rsp_value_ff <= rsp_value_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.out_slot   = rsp_slot_ff;
   assign rsp_ch.axis_code  = rsp_code_ff;
   assign rsp_ch.axis_value = rsp_value_ff;
   assign rsp_ch.last_event = rsp_last_ff;

endmodule

// ----- src/srd_checker.sv -----
// ----------------------------------------------------------------------------
// srd_checker: port-level checks for the radial dead zone block
// Watches the result channel and configuration port over time.
// ----------------------------------------------------------------------------
module srd_checker (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [1:0]         axis_code,
   input logic signed [15:0] axis_value,
   input logic               last_event,
   input logic               csr_pready
);

   // a stalled event keeps its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(axis_value) && $stable(axis_code)
                                  && $stable(last_event))
      else $error("stalled event changed");

   // conditioned values stay within +-32767
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> axis_value != 16'sh8000)
      else $error("axis value out of range");

   // reset empties the output register
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("event after reset");

   // a non-final right y event cannot exist
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && axis_code == srd_pkg::AXIS_RY |-> last_event)
      else $error("right y not flagged last");

   assert property (@(posedge clock) disable iff (reset) csr_pready)
      else $error("pready low");

endmodule

bind stick_radial_deadzone_core srd_checker u_srd_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_valid  (rsp_ch.valid),
   .rsp_ready  (rsp_ch.ready),
   .axis_code  (rsp_ch.axis_code),
   .axis_value (rsp_ch.axis_value),
   .last_event (rsp_ch.last_event),
   .csr_pready (csr_pready)
);

// ----- verif/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top: testbench for stick_radial_deadzone_core
// Drives pad frames with random idling, predicts axis events from an internal
// model of the dead zone and change filter, and checks each event in order.
// ----------------------------------------------------------------------------
module tb_top;

   typedef struct packed {
      logic [2:0]         slot;
      logic [1:0]         axis;
      logic signed [15:0] value;
      logic               last;
   } axis_event_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic        csr_psel = 1'b0, csr_penable = 1'b0, csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   srd_req_if req_ch ();
   srd_rsp_if rsp_ch ();

   stick_radial_deadzone_core i_dut (
      .clock(clock), .reset(reset), .req_ch(req_ch), .rsp_ch(rsp_ch),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // model state
   logic [14:0]        zone_radius;
   logic               sideways;
   logic signed [15:0] stored_axis [0:31];
   axis_event_type     pending_events[$];
   int                 fail_count = 0;
   int                 csr_fail_count = 0;
   int                 cycle_count = 0;
   bit                 quiet = 1'b0;

   function automatic logic [63:0] root_floor(input logic [63:0] s);
      logic [63:0] root, bitv;
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv > s) bitv >>= 2;
      while (bitv != 0) begin
         if (s >= root + bitv) begin
            s -= root + bitv;
            root = (root >> 1) + bitv;
         end else begin
            root >>= 1;
         end
         bitv >>= 2;
      end
      return root;
   endfunction

   function automatic int shape_axis(input int a, input int b, input int dz);
      longint unsigned ua, ub, s, m, num, den, q;
      ua = longint'(a < 0 ? -a : a);
      ub = longint'(b < 0 ? -b : b);
      s = ua * ua + ub * ub;
      if (s < longint'(dz) * dz) return 0;
      m = root_floor(s);
      if (m == 0) return 0;
      num = ua * (m - dz) * 32767;
      den = m * (32767 - dz);
      q = (num + den / 2) / den;
      if (q > 32767) q = 32767;
      return a < 0 ? -int'(q) : int'(q);
   endfunction

   function automatic void predict_frame(input logic [2:0] slot, input logic det,
                                         input logic [1:0] style, input int s0x,
                                         input int s0y, input int s1x, input int s1y);
      int lx, ly, rx, ry, t, d, dz, n;
      int vals[4];
      axis_event_type ev;
      dz = int'(zone_radius > srd_pkg::DZ_MAX ? srd_pkg::DZ_MAX : zone_radius);
      if (slot >= srd_pkg::PAD_SLOTS_DEFAULT) return;
      if (det) begin
         for (int k = 0; k < 4; k++) stored_axis[slot*4+k] = '0;
         return;
      end
      if (style == srd_pkg::STYLE_RIGHT) begin
         lx = s1x; ly = s1y; rx = s0x; ry = s0y;
      end else begin
         lx = s0x; ly = s0y; rx = s1x; ry = s1y;
      end
      if (sideways && (style == srd_pkg::STYLE_LEFT || style == srd_pkg::STYLE_RIGHT)) begin
         t = lx;
         if (style == srd_pkg::STYLE_LEFT) begin
            lx = -ly; ly = t;
         end else begin
            lx = ly; ly = -t;
         end
      end
      vals[0] = shape_axis(lx, ly, dz);
      vals[1] = -shape_axis(ly, lx, dz);
      vals[2] = shape_axis(rx, ry, dz);
      vals[3] = -shape_axis(ry, rx, dz);
      n = 0;
      for (int k = 0; k < 4; k++) begin
         d = vals[k] - stored_axis[slot*4+k];
         if (d < 0) d = -d;
         if (d >= srd_pkg::MOVE_STEP) begin
            stored_axis[slot*4+k] = 16'(vals[k]);
            ev.slot = slot; ev.axis = 2'(k); ev.value = 16'(vals[k]); ev.last = 1'b0;
            pending_events.push_back(ev);
            n++;
         end
      end
      if (n > 0) pending_events[$].last = 1'b1;
   endfunction

   // result side: compare with oldest expectation
   always @(posedge clock) begin
      axis_event_type exp_ev;
      cycle_count <= cycle_count + 1;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_events.size() == 0) begin
            $error("unexpected event slot %0d axis %0d value %0d",
                   rsp_ch.out_slot, rsp_ch.axis_code, rsp_ch.axis_value);
            fail_count++;
         end else begin
            exp_ev = pending_events.pop_front();
            if (rsp_ch.out_slot !== exp_ev.slot) begin
               $error("out_slot exp %0d got %0d", exp_ev.slot, rsp_ch.out_slot);
               fail_count++;
            end
            if (rsp_ch.axis_code !== exp_ev.axis) begin
               $error("axis_code exp %0d got %0d", exp_ev.axis, rsp_ch.axis_code);
               fail_count++;
            end
            if (rsp_ch.axis_value !== exp_ev.value) begin
               $error("axis_value exp %0d got %0d", exp_ev.value, rsp_ch.axis_value);
               fail_count++;
            end
            if (rsp_ch.last_event !== exp_ev.last) begin
               $error("last_event exp %0d got %0d", exp_ev.last, rsp_ch.last_event);
               fail_count++;
            end
         end
      end
   end

   // random stall bursts on the result side
   int stall_left = 0;
   always @(posedge clock) begin
      if (quiet) begin
         rsp_ch.ready <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_ch.ready <= 1'b0;
      end else if ($urandom_range(0, 9) == 0) begin
         stall_left <= $urandom_range(1, 18);
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (cycle_count > 400000) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // valid stays high after an accept until the next item, an idle burst or a drain
   task automatic send_frame(input logic [2:0] slot, input logic det,
                             input logic [1:0] style, input logic [15:0] s0x,
                             input logic [15:0] s0y, input logic [15:0] s1x,
                             input logic [15:0] s1y);
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      req_ch.valid <= 1'b1; req_ch.pad_slot <= slot; req_ch.detach <= det;
      req_ch.pad_style <= style;
      req_ch.stick0_x <= s0x; req_ch.stick0_y <= s0y;
      req_ch.stick1_x <= s1x; req_ch.stick1_y <= s1y;
      do @(posedge clock); while (!req_ch.ready);
      predict_frame(slot, det, style, int'($signed(s0x)), int'($signed(s0y)),
                    int'($signed(s1x)), int'($signed(s1y)));
   endtask

   task automatic drain_results();
      req_ch.valid <= 1'b0;
      while (pending_events.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   task automatic write_reg(input logic regsel, input logic [31:0] data);
      logic [31:0] exp_rd;
      exp_rd = (regsel == srd_pkg::REG_DEAD_ZONE) ? {17'd0, data[14:0]}
                                                  : {31'd0, data[0]};
      @(posedge clock);
      csr_psel <= 1'b1; csr_penable <= 1'b0; csr_pwrite <= 1'b1;
      csr_paddr <= {regsel, 2'b00}; csr_pwdata <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      // read back
      csr_penable <= 1'b0; csr_pwrite <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== exp_rd) begin
         $error("csr_prdata exp %0h got %0h", exp_rd, csr_prdata);
         csr_fail_count++;
      end
      csr_psel <= 1'b0; csr_penable <= 1'b0;
      if (regsel == srd_pkg::REG_DEAD_ZONE) zone_radius = data[14:0];
      else sideways = data[0];
   endtask

   function automatic logic [15:0] rand_raw();
      case ($urandom_range(0, 5))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'($urandom_range(0, 2000) - 1000);
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic random_frame();
      logic [2:0] slot;
      slot = 3'($urandom_range(0, 7));
      if ($urandom_range(0, 19) == 0)
         send_frame(slot, 1'b1, 2'($urandom), 16'($urandom), 16'($urandom),
                    16'($urandom), 16'($urandom));
      else
         send_frame(slot, 1'b0, 2'($urandom_range(0, 3)), rand_raw(), rand_raw(),
                    rand_raw(), rand_raw());
   endtask

   task automatic test_directed_edges();
      send_frame(3'd0, 1'b0, srd_pkg::STYLE_FULL, 16'h7FFF, 16'h0000, 16'h8000, 16'h0000);
      send_frame(3'd0, 1'b0, srd_pkg::STYLE_FULL, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF);
      send_frame(3'd1, 1'b0, srd_pkg::STYLE_LEFT, 16'h0100, 16'h0100, 16'h0000, 16'h0000);
      send_frame(3'd1, 1'b0, srd_pkg::STYLE_RIGHT, 16'h4000, 16'hC000, 16'h2000, 16'h6000);
      // unused style code behaves as a full controller
      send_frame(3'd2, 1'b0, 2'd3, 16'h5000, 16'h1000, 16'hB000, 16'hF000);
      // repeat within step: nothing emitted
      send_frame(3'd2, 1'b0, 2'd3, 16'h5010, 16'h1000, 16'hB000, 16'hF000);
      send_frame(3'd2, 1'b1, srd_pkg::STYLE_FULL, 16'h0, 16'h0, 16'h0, 16'h0);
      send_frame(3'd2, 1'b0, srd_pkg::STYLE_FULL, 16'h5000, 16'h1000, 16'hB000, 16'hF000);
      send_frame(3'd7, 1'b0, srd_pkg::STYLE_FULL, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_frame(3'd7, 1'b0, srd_pkg::STYLE_FULL, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
      drain_results();
   endtask

   task automatic test_sideways();
      write_reg(srd_pkg::REG_SIDEWAYS, 32'd1);
      send_frame(3'd3, 1'b0, srd_pkg::STYLE_LEFT, 16'h6000, 16'h1000, 16'h7000, 16'h7000);
      send_frame(3'd4, 1'b0, srd_pkg::STYLE_RIGHT, 16'h6000, 16'h1000, 16'h9000, 16'h2000);
      send_frame(3'd5, 1'b0, srd_pkg::STYLE_FULL, 16'h6000, 16'h1000, 16'h9000, 16'h2000);
      repeat (40) random_frame();
      drain_results();
      write_reg(srd_pkg::REG_SIDEWAYS, 32'd0);
   endtask

   task automatic test_zone_extremes();
      write_reg(srd_pkg::REG_DEAD_ZONE, 32'd0);
      send_frame(3'd6, 1'b0, srd_pkg::STYLE_FULL, 16'h0001, 16'hFFFF, 16'h8000, 16'h7FFF);
      repeat (30) random_frame();
      drain_results();
      // full-scale zone is clamped one below
      write_reg(srd_pkg::REG_DEAD_ZONE, 32'h7FFF);
      send_frame(3'd6, 1'b0, srd_pkg::STYLE_FULL, 16'h8000, 16'h8000, 16'h7FFF, 16'h0000);
      repeat (20) random_frame();
      drain_results();
      write_reg(srd_pkg::REG_DEAD_ZONE, 32'd32766);
      repeat (20) random_frame();
      drain_results();
   endtask

   task automatic test_random_mix();
      for (int p = 0; p < 4; p++) begin
         write_reg(srd_pkg::REG_DEAD_ZONE, $urandom_range(0, 12000));
         write_reg(srd_pkg::REG_SIDEWAYS, $urandom_range(0, 1));
         repeat (30) random_frame();
         drain_results();
      end
      quiet = 1'b1;
      repeat (25) random_frame();
      drain_results();
   endtask

   initial begin
      req_ch.valid = 1'b0; req_ch.pad_slot = '0; req_ch.detach = 1'b0;
      req_ch.pad_style = '0; req_ch.stick0_x = '0; req_ch.stick0_y = '0;
      req_ch.stick1_x = '0; req_ch.stick1_y = '0;
      zone_radius = srd_pkg::DZ_RESET;
      sideways = 1'b0;
      for (int k = 0; k < 32; k++) stored_axis[k] = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_directed_edges();
      test_sideways();
      test_zone_extremes();
      test_random_mix();
      if (fail_count == 0 && csr_fail_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

// ----- files.f -----
src/srd_pkg.sv
src/srd_req_if.sv
src/srd_rsp_if.sv
src/srd_ram.sv
src/srd_lane.sv
src/stick_radial_deadzone_core.sv
src/srd_checker.sv
verif/tb_top.sv
